// ===== hw/rtl/sls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sls_pkg;
	localparam int unsigned STACK_DEPTH_DEF = 128;
	localparam int unsigned ID_WIDTH_DEF = 16;
	localparam int unsigned MT_N = 624;
	localparam int unsigned MT_M = 397;
	localparam int unsigned MT_IDX_W = 10;
	localparam logic [31:0] SEED_RESET = 32'd5489;
	localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX_A = 32'h9908b0df;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_SHUFFLE = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load_req;
		logic mt_init_start;
		logic mt_twist_start;
		logic draw_start;
		logic swap_start;
		logic finish;
	} sls_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic unit_done;
		logic need_twist;
		logic shuffle_more;
		logic is_shuffle;
		logic empty_shuffle;
	} sls_status_t;

	function automatic logic [31:0] mt_temper(input logic [31:0] x);
		logic [31:0] y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9d2c5680);
		y = y ^ ((y << 15) & 32'hefc60000);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sls_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// serial restoring remainder: 32-bit dividend by up to 32-bit divisor, one bit a cycle
module sls_mod_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [31:0] dividend,
	input  wire [31:0] divisor,
	output logic       done,
	output logic [31:0] remainder
);
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign diff = shifted - {1'b0, div_q};
	assign remainder = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			div_q <= '0;
			rem_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
				quo_q <= dividend;
				div_q <= divisor;
				rem_q <= '0;
			end else if (run_q) begin
				quo_q <= {quo_q[30:0], 1'b0};
				rem_q <= diff[32] ? shifted : diff;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sls_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sls_datapath #(
	parameter int unsigned STACK_DEPTH = sls_pkg::STACK_DEPTH_DEF,
	parameter int unsigned ID_WIDTH = sls_pkg::ID_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire sls_pkg::sls_cmd_t cmd,
	output sls_pkg::sls_status_t   status,
	input  wire [1:0]              req_type,
	input  wire [15:0]             item_id,
	input  wire                    seed_we,
	input  wire [31:0]             seed_data,
	output logic                   done,
	output logic [15:0]            popped_id,
	output logic                   popped_valid,
	output logic                   overflow,
	output logic [7:0]             item_count
);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned MW = sls_pkg::MT_IDX_W;

	typedef enum logic [3:0] {
		U_IDLE, U_INIT, U_IN_MUL, U_TW_RD0, U_TW_RD1, U_TW_RD2, U_TW_WR,
		U_DR_RD, U_DR_MOD, U_SW_RD, U_SW_WR, U_PP_RD, U_PP_OUT
	} unit_t;

	unit_t            u_q;
	logic [ID_WIDTH-1:0] store_q [STACK_DEPTH];
	logic [31:0]      mt_q [sls_pkg::MT_N];
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    pos_q;
	logic [AW-1:0]    j_q;
	logic [MW-1:0]    mti_q;
	logic [MW-1:0]    k_q;
	logic [31:0]      seed_q;
	logic             seed_pend_q;
	logic [31:0]      prev_q;
	logic [31:0]      w0_q, w1_q, wm_q;
	logic [31:0]      rd_q;
	logic [ID_WIDTH-1:0] a_q, b_q;
	logic [1:0]       op_q;
	logic             mod_start;
	logic             mod_done;
	logic [31:0]      mod_rem;
	logic [31:0]      span;
	logic [31:0]      ty;
	logic [31:0]      tv;
	logic [31:0]      init_p;
	logic [31:0]      init_v;
	logic [MW-1:0]    k1, km;

	assign span = 32'(cnt_q) - 32'(pos_q);
	assign mod_start = (u_q == U_DR_RD);

	sls_mod_unit u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend(sls_pkg::mt_temper(rd_q)), .divisor(span),
		.done(mod_done), .remainder(mod_rem)
	);

	assign k1 = (k_q == MW'(sls_pkg::MT_N - 1)) ? '0 : k_q + MW'(1);
	assign km = (k_q >= MW'(sls_pkg::MT_N - sls_pkg::MT_M)) ?
		k_q - MW'(sls_pkg::MT_N - sls_pkg::MT_M) : k_q + MW'(sls_pkg::MT_M);
	assign ty = {w0_q[31], w1_q[30:0]};
	assign tv = wm_q ^ (ty >> 1) ^ (ty[0] ? sls_pkg::MT_MATRIX_A : 32'd0);
	// word just written by the init pass, folded for the next multiply
	assign init_p = (k_q == '0) ? seed_q : prev_q;
	assign init_v = init_p ^ (init_p >> 30);

	always_comb begin
		status.unit_done = (u_q == U_IDLE);
		status.need_twist = (mti_q >= MW'(sls_pkg::MT_N));
		status.shuffle_more = (32'(pos_q) < 32'(cnt_q));
		status.is_shuffle = (op_q == sls_pkg::OP_SHUFFLE);
		status.empty_shuffle = (cnt_q == '0);
	end

	// generator words: one write port, read data registered
	always_ff @(posedge clk) begin
		if (u_q == U_INIT) begin
			mt_q[k_q] <= (k_q == '0) ? seed_q : prev_q;
		end else if (u_q == U_TW_WR) begin
			mt_q[k_q] <= tv;
		end
		unique case (u_q)
			U_TW_RD0: w0_q <= mt_q[k_q];
			U_TW_RD1: w1_q <= mt_q[k1];
			U_TW_RD2: wm_q <= mt_q[km];
			default: rd_q <= mt_q[mti_q];
		endcase
	end

	// stack memory: swap reads both entries, then writes them back crossed
	always_ff @(posedge clk) begin
		if (cmd.load_req && req_type == sls_pkg::OP_PUSH && cnt_q < CW'(STACK_DEPTH)) begin
			store_q[cnt_q[AW-1:0]] <= item_id[ID_WIDTH-1:0];
		end else if (u_q == U_PP_RD) begin
			store_q[pos_q[AW-1:0]] <= b_q;
		end else if (u_q == U_PP_OUT) begin
			store_q[j_q] <= a_q;
		end
		if (u_q == U_SW_RD) a_q <= store_q[pos_q[AW-1:0]];
		if (u_q == U_SW_WR) b_q <= store_q[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q <= U_INIT;
			k_q <= '0;
			mti_q <= MW'(sls_pkg::MT_N);
			seed_q <= sls_pkg::SEED_RESET;
			prev_q <= sls_pkg::SEED_RESET;
			seed_pend_q <= 1'b0;
			cnt_q <= '0;
			pos_q <= '0;
			j_q <= '0;
			op_q <= '0;
			done <= 1'b0;
			popped_id <= '0;
			popped_valid <= 1'b0;
			overflow <= 1'b0;
			item_count <= '0;
		end else begin
			done <= 1'b0;
			if (seed_we) begin
				seed_q <= seed_data;
				prev_q <= seed_data;
				seed_pend_q <= 1'b1;
			end
			if (cmd.load_req) begin
				op_q <= req_type;
				popped_id <= '0;
				popped_valid <= 1'b0;
				overflow <= 1'b0;
				pos_q <= '0;
				unique case (req_type)
					sls_pkg::OP_PUSH: begin
						if (cnt_q < CW'(STACK_DEPTH)) cnt_q <= cnt_q + CW'(1);
						else overflow <= 1'b1;
					end
					sls_pkg::OP_POP: begin
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - CW'(1);
							popped_id <= 16'(store_q[AW'(cnt_q - CW'(1))]);
							popped_valid <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.finish) begin
				done <= 1'b1;
				item_count <= 8'(cnt_q);
			end
			if (cmd.mt_init_start && seed_pend_q) begin
				u_q <= U_INIT;
				k_q <= '0;
				seed_pend_q <= 1'b0;
			end
			unique case (u_q)
				U_IDLE: begin
					if (cmd.mt_twist_start) begin
						u_q <= U_TW_RD0;
						k_q <= '0;
					end else if (cmd.draw_start) begin
						u_q <= U_DR_RD;
					end else if (cmd.swap_start) begin
						u_q <= U_SW_RD;
					end
				end
				U_INIT: begin
					// k-th word written this cycle; prepare next
					prev_q <= init_v;
					k_q <= k_q + MW'(1);
					if (k_q == MW'(sls_pkg::MT_N - 1)) begin
						u_q <= U_IDLE;
						mti_q <= MW'(sls_pkg::MT_N);
					end else begin
						u_q <= U_IN_MUL;
					end
				end
				U_IN_MUL: begin
					// prev_q holds p ^ (p >> 30), k_q the index of the next word
					prev_q <= 32'(prev_q * sls_pkg::MT_INIT_MULT + 32'(k_q));
					u_q <= U_INIT;
				end
				U_TW_RD0: u_q <= U_TW_RD1;
				U_TW_RD1: u_q <= U_TW_RD2;
				U_TW_RD2: u_q <= U_TW_WR;
				U_TW_WR: begin
					if (k_q == MW'(sls_pkg::MT_N - 1)) begin
						mti_q <= '0;
						u_q <= U_IDLE;
					end else begin
						k_q <= k_q + MW'(1);
						u_q <= U_TW_RD0;
					end
				end
				U_DR_RD: u_q <= U_DR_MOD;
				U_DR_MOD: begin
					if (mod_done) begin
						mti_q <= mti_q + MW'(1);
						j_q <= AW'(32'(pos_q) + mod_rem);
						u_q <= U_SW_RD;
					end
				end
				U_SW_RD: u_q <= U_SW_WR;
				U_SW_WR: u_q <= U_PP_RD;
				U_PP_RD: u_q <= U_PP_OUT;
				U_PP_OUT: begin
					pos_q <= pos_q + CW'(1);
					u_q <= U_IDLE;
				end
				default: u_q <= U_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sls_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire sls_pkg::sls_status_t status,
	output sls_pkg::sls_cmd_t         cmd,
	output logic                      busy
);
	typedef enum logic [2:0] {S_IDLE, S_OP, S_TWCHK, S_TWWAIT, S_DRAW, S_WAIT, S_FIN} state_t;
	state_t st_q;

	always_comb begin
		cmd = '0;
		cmd.load_req = start && !busy;
		cmd.mt_init_start = (st_q == S_OP) && status.is_shuffle;
		cmd.mt_twist_start = (st_q == S_TWCHK) && status.unit_done && status.need_twist;
		cmd.draw_start = (st_q == S_TWCHK) && status.unit_done && !status.need_twist;
		cmd.finish = (st_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			busy <= 1'b1;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					busy <= !status.unit_done;
					if (start && !busy) begin
						st_q <= S_OP;
						busy <= 1'b1;
					end
				end
				S_OP: st_q <= (status.is_shuffle && !status.empty_shuffle) ? S_WAIT : S_FIN;
				S_WAIT: if (status.unit_done) st_q <= S_TWCHK;
				S_TWCHK: if (status.unit_done) st_q <= status.need_twist ? S_TWWAIT : S_DRAW;
				S_TWWAIT: if (status.unit_done) st_q <= S_TWCHK;
				S_DRAW: if (status.unit_done) st_q <= status.shuffle_more ? S_TWCHK : S_FIN;
				S_FIN: begin
					st_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/shuffling_lifo_stack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// push, pop and reserved codes go from S_OP to S_FIN, from which done is registered;
// shuffle draws and swaps one entry per pass, plus a twist whenever the 624-word table runs out
// one operation at a time: busy stays high until done;
// shuffle time set by the serial modulo unit; first shuffle after a seed write adds an init pass
// reset: stack empty, generator seeded with 5489 over an init pass (busy high)
// the receiver cannot stall: each result shows for one cycle with done
module shuffling_lifo_stack_top #(
	parameter int unsigned STACK_DEPTH = sls_pkg::STACK_DEPTH_DEF,
	parameter int unsigned ID_WIDTH = sls_pkg::ID_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [1:0]  req_type,
	input  wire [15:0] item_id,
	input  wire        seed_we,
	input  wire [31:0] seed_data,
	output logic       done,
	output logic [15:0] popped_id,
	output logic       popped_valid,
	output logic       overflow,
	output logic [7:0] item_count
);
	sls_pkg::sls_cmd_t    cmd;
	sls_pkg::sls_status_t status;

	// sequencer
	sls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.status(status), .cmd(cmd), .busy(busy)
	);

	// stack and generator storage
	sls_datapath #(.STACK_DEPTH(STACK_DEPTH), .ID_WIDTH(ID_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.req_type(req_type), .item_id(item_id),
		.seed_we(seed_we), .seed_data(seed_data),
		.done(done), .popped_id(popped_id), .popped_valid(popped_valid),
		.overflow(overflow), .item_count(item_count)
	);

`ifndef SYNTHESIS
	a_pop_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(popped_valid && overflow)) else $error("pop and overflow together");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
`endif
endmodule
`default_nettype wire
